// ===== rtl/assert_macros.svh =====
// Assertion macros used by euler_flux_3d.
// Depends on nothing; taken in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Condition that must never be true on a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  `ASSERT_CLK(lbl, clk, rstn, !(cond))

`endif

// ===== rtl/ef3_pkg.sv =====
// Package for the 3D Euler flux block: default widths, codes, control types.
// Used by ef3_lane and euler_flux_3d; depends on nothing.
`default_nettype none
package ef3_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int GAMMA_W        = 18;
  localparam int ROW_W          = 3;
  localparam int STATUS_W       = 2;

  localparam logic [GAMMA_W-1:0]  GAMMA_RESET    = 18'd91750;
  localparam logic [ROW_W-1:0]    ROW_MASS       = 3'd0;
  localparam logic [ROW_W-1:0]    ROW_MOM_X      = 3'd1;
  localparam logic [ROW_W-1:0]    ROW_MOM_Y      = 3'd2;
  localparam logic [ROW_W-1:0]    ROW_MOM_Z      = 3'd3;
  localparam logic [ROW_W-1:0]    ROW_ENERGY     = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_RHO = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NEG_P   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_DIV,
    ST_WAIT,
    ST_INNER,
    ST_PMUL,
    ST_PRES,
    ST_ROW0,
    ST_MUL,
    ST_EMIT,
    ST_ERR
  } eng_state_e;

  typedef struct packed {
    logic start_div;
    logic sq_en;
    logic mul_en;
    logic add_p;
  } lane_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/ef3_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Standalone; used by ef3_lane and euler_flux_3d.
`default_nettype none
module ef3_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  busy_o,
  output logic [NUM_W-1:0]      quo_o
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] nq_q;
  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, nq_q[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  assign rem_d   = rem_sub[DEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NUM_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      nq_q  <= {nq_q[NUM_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = nq_q;

endmodule
`default_nettype wire

// ===== rtl/ef3_lane.sv =====
// One direction lane: velocity divider, shared multiplier, flux component.
// Depends on ef3_pkg and ef3_div.
`default_nettype none
module ef3_lane import ef3_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lane_ctrl_t                   ctrl_i,
  input  wire logic        [DATA_WIDTH-1:0] rho_i,
  input  wire logic signed [DATA_WIDTH-1:0] mom_i,
  input  wire logic signed [DATA_WIDTH-1:0] mul_a_i,
  input  wire logic signed [DATA_WIDTH-1:0] pres_i,
  output logic                              busy_o,
  output logic [2*DATA_WIDTH-1:0]           sq_o,
  output logic signed [DATA_WIDTH-1:0]      flux_o
);

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int QW = DW + FB;
  localparam int PW = 2 * DW;
  localparam logic [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  logic [DW-1:0]        abs_m;
  logic [QW-1:0]        quo;
  logic                 neg_q;
  logic                 big;
  logic [DW-1:0]        vel_d;
  logic signed [DW-1:0] vel_q;
  logic signed [PW-1:0] prod_q;
  logic                 add_p_q;
  logic signed [PW-1:0] bias, tsum, tq;
  logic signed [PW:0]   fsum;
  logic [PW-DW+1:0]     top_bits;

  assign abs_m = mom_i[DW-1] ? (~mom_i + 1'b1) : mom_i;

  ef3_div #(
    .NUM_W(QW),
    .DEN_W(DW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ctrl_i.start_div),
    .num_i  ({abs_m, {FB{1'b0}}}),
    .den_i  (rho_i),
    .busy_o (busy_o),
    .quo_o  (quo)
  );

  assign big = |quo[QW-1:DW-1];

  always_comb begin
    if (neg_q) begin
      vel_d = big ? SAT_MIN : (~quo[DW-1:0] + 1'b1);
    end else begin
      vel_d = big ? SAT_MAX : quo[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start_div) begin
      neg_q <= mom_i[DW-1];
    end
    vel_q <= vel_d;
    if (ctrl_i.sq_en) begin
      prod_q <= mom_i * mom_i;
    end else if (ctrl_i.mul_en) begin
      prod_q  <= mul_a_i * vel_q;
      add_p_q <= ctrl_i.add_p;
    end
  end

  assign sq_o = prod_q;

  // product / 2^FB, truncated toward zero, plus pressure on the diagonal
  assign bias = prod_q[PW-1] ? PW'({FB{1'b1}}) : '0;
  assign tsum = prod_q + bias;
  assign tq   = tsum >>> FB;
  assign fsum = {tq[PW-1], tq} + (add_p_q ? (PW+1)'(pres_i) : '0);
  assign top_bits = fsum[PW:DW-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      flux_o = fsum[DW-1:0];
    end else begin
      flux_o = fsum[PW] ? SAT_MIN : SAT_MAX;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/euler_flux_3d.sv =====
// Each state runs ST_SQUARE, ST_SUM, ST_DIV, ST_WAIT, ST_INNER, ST_PMUL, ST_PRES,
// then emits rows via ST_ROW0, ST_MUL and ST_EMIT; a bad density or a negative
// pressure leads to ST_ERR instead. Processing time per state is set by the
// kinetic-energy divider, which retires one quotient bit a cycle.
// One input state is buffered while the previous one is processed.
// Reset: asynchronous active low; clears control state, gamma returns to 1.4.
`default_nettype none
`include "assert_macros.svh"
module euler_flux_3d import ef3_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [GAMMA_W-1:0]      cfg_wdata_i,
  input  wire logic                    s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // density, momentum_x, momentum_y, momentum_z, total_energy
  input  wire logic [((5*DATA_WIDTH+7)>>3)*8-1:0] s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  wire logic                    m_axis_tready_i,
  // flux_x, flux_y, flux_z
  output logic [((3*DATA_WIDTH+7)>>3)*8-1:0] m_axis_tdata_o,
  // flux_row, status
  output logic [ROW_W+STATUS_W-1:0]    m_axis_tuser_o,
  output logic                         m_axis_tlast_o
);

  localparam int DW   = DATA_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int IN_W = 5 * DW;
  localparam int OTW  = ((3 * DW + 7) >> 3) * 8;
  localparam int KN_W = 2 * DW + 2;
  localparam int DF_W = KN_W + 2;
  localparam int GM_W = ((GAMMA_W > FB) ? GAMMA_W : FB + 1) + 1;
  localparam int PP_W = GM_W + DW;
  localparam logic [GM_W-1:0] ONE_G   = GM_W'(1) << FB;
  localparam logic [DW-1:0]   SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0]   SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  // input buffer
  logic            in_valid_q, in_valid_d;
  logic [IN_W-1:0] in_data_q;
  logic            take;
  logic            in_acc;
  logic [DW-1:0]   in_rho;
  logic            rho_bad;

  logic [GAMMA_W-1:0] gamma_q;

  eng_state_e state_q, state_d;
  logic [ROW_W-1:0]    row_q;
  logic [STATUS_W-1:0] err_q;

  logic signed [DW-1:0] rho_q, e_q, inner_q, p_q, h_q;
  logic signed [DW-1:0] mom_q [3];
  logic [KN_W-1:0]      sq_q;
  logic signed [PP_W-1:0] pprod_q;

  // lanes
  lane_ctrl_t           lane_ctrl [3];
  logic                 lane_busy [3];
  logic [2*DW-1:0]      lane_sq   [3];
  logic signed [DW-1:0] lane_flux [3];
  logic signed [DW-1:0] mul_a;

  logic            kin_start, kin_busy;
  logic [KN_W-1:0] ke;
  logic            all_done;

  logic signed [DF_W-1:0] diff;
  logic [DF_W-DW:0]       diff_top;
  logic [DW-1:0]          inner_d;
  logic signed [GM_W-1:0] gm1;
  logic signed [PP_W-1:0] pbias, psum, pq;
  logic [PP_W-DW:0]       p_top;
  logic [DW-1:0]          p_d;
  logic signed [DW:0]     hsum;
  logic [DW-1:0]          h_d;

  // output register
  logic                out_valid_q;
  logic [3*DW-1:0]     out_data_q, out_data_d;
  logic [ROW_W-1:0]    out_row_q, out_row_d;
  logic [STATUS_W-1:0] out_stat_q, out_stat_d;
  logic                out_last_q, out_last_d;
  logic                out_ok, out_load;
  logic                row_is_last;
  logic                out_err;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !in_valid_q;
  assign in_rho          = in_data_q[DW-1:0];
  assign rho_bad         = in_rho[DW-1] || !(|in_rho);

  always_comb begin
    in_valid_d = in_valid_q;
    if (take) begin
      in_valid_d = 1'b0;
    end
    if (in_acc) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      gamma_q    <= GAMMA_RESET;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_we_i) begin
        gamma_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_data_q <= s_axis_tdata_i[IN_W-1:0];
    end
  end

  // lanes: x, y, z
  for (genvar j = 0; j < 3; j++) begin : g_lane
    ef3_lane #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (lane_ctrl[j]),
      .rho_i  (rho_q),
      .mom_i  (mom_q[j]),
      .mul_a_i(mul_a),
      .pres_i (p_q),
      .busy_o (lane_busy[j]),
      .sq_o   (lane_sq[j]),
      .flux_o (lane_flux[j])
    );
  end

  ef3_div #(
    .NUM_W(KN_W),
    .DEN_W(DW)
  ) u_kin_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(kin_start),
    .num_i  (sq_q),
    .den_i  ({rho_q[DW-2:0], 1'b0}),
    .busy_o (kin_busy),
    .quo_o  (ke)
  );

  assign all_done = !kin_busy && !lane_busy[0] && !lane_busy[1] && !lane_busy[2];

  // inner energy, saturated
  assign diff     = DF_W'(e_q) - $signed({2'b00, ke});
  assign diff_top = diff[DF_W-1:DW-1];
  always_comb begin
    if ((&diff_top) || !(|diff_top)) begin
      inner_d = diff[DW-1:0];
    end else begin
      inner_d = diff[DF_W-1] ? SAT_MIN : SAT_MAX;
    end
  end

  // pressure: (gamma-1)*inner / 2^FB, truncated toward zero, saturated
  assign gm1   = $signed(GM_W'(gamma_q)) - $signed(ONE_G);
  assign pbias = pprod_q[PP_W-1] ? PP_W'({FB{1'b1}}) : '0;
  assign psum  = pprod_q + pbias;
  assign pq    = psum >>> FB;
  assign p_top = pq[PP_W-1:DW-1];
  always_comb begin
    if ((&p_top) || !(|p_top)) begin
      p_d = pq[DW-1:0];
    end else begin
      p_d = pq[PP_W-1] ? SAT_MIN : SAT_MAX;
    end
  end

  // enthalpy term
  assign hsum = {e_q[DW-1], e_q} + {p_q[DW-1], p_q};
  always_comb begin
    if (hsum[DW] == hsum[DW-1]) begin
      h_d = hsum[DW-1:0];
    end else begin
      h_d = hsum[DW] ? SAT_MIN : SAT_MAX;
    end
  end

  assign out_ok      = !out_valid_q || m_axis_tready_i;
  assign row_is_last = (row_q == ROW_ENERGY);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_q) begin
          state_d = rho_bad ? ST_ERR : ST_SQUARE;
        end
      end
      ST_SQUARE: state_d = ST_SUM;
      ST_SUM:    state_d = ST_DIV;
      ST_DIV:    state_d = ST_WAIT;
      ST_WAIT: begin
        if (all_done) begin
          state_d = ST_INNER;
        end
      end
      ST_INNER: state_d = ST_PMUL;
      ST_PMUL:  state_d = ST_PRES;
      ST_PRES:  state_d = p_d[DW-1] ? ST_ERR : ST_ROW0;
      ST_ROW0: begin
        if (out_ok) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_ok) begin
          state_d = row_is_last ? ST_IDLE : ST_MUL;
        end
      end
      ST_ERR: begin
        if (out_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    take       = 1'b0;
    kin_start  = 1'b0;
    out_load   = 1'b0;
    out_data_d = '0;
    out_row_d  = ROW_MASS;
    out_stat_d = STATUS_OK;
    out_last_d = 1'b0;
    mul_a      = mom_q[0];
    for (int j = 0; j < 3; j++) begin
      lane_ctrl[j] = '0;
    end
    unique case (row_q)
      ROW_MOM_X:  mul_a = mom_q[0];
      ROW_MOM_Y:  mul_a = mom_q[1];
      ROW_MOM_Z:  mul_a = mom_q[2];
      ROW_ENERGY: mul_a = h_q;
      default:    mul_a = mom_q[0];
    endcase
    unique case (state_q)
      ST_IDLE: take = in_valid_q;
      ST_SQUARE: begin
        for (int j = 0; j < 3; j++) begin
          lane_ctrl[j].sq_en = 1'b1;
        end
      end
      ST_DIV: begin
        kin_start = 1'b1;
        for (int j = 0; j < 3; j++) begin
          lane_ctrl[j].start_div = 1'b1;
        end
      end
      ST_ROW0: begin
        out_load   = out_ok;
        out_data_d = {mom_q[2], mom_q[1], mom_q[0]};
        out_row_d  = ROW_MASS;
      end
      ST_MUL: begin
        for (int j = 0; j < 3; j++) begin
          lane_ctrl[j].mul_en = 1'b1;
        end
        lane_ctrl[0].add_p = (row_q == ROW_MOM_X);
        lane_ctrl[1].add_p = (row_q == ROW_MOM_Y);
        lane_ctrl[2].add_p = (row_q == ROW_MOM_Z);
      end
      ST_EMIT: begin
        out_load   = out_ok;
        out_data_d = {lane_flux[2], lane_flux[1], lane_flux[0]};
        out_row_d  = row_q;
        out_last_d = row_is_last;
      end
      ST_ERR: begin
        out_load   = out_ok;
        out_stat_d = err_q;
        out_last_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= ROW_MASS;
      err_q       <= STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take) begin
        err_q <= STATUS_BAD_RHO;
      end else if (state_q == ST_PRES) begin
        err_q <= STATUS_NEG_P;
      end
      if (state_q == ST_ROW0 && out_ok) begin
        row_q <= ROW_MOM_X;
      end else if (state_q == ST_EMIT && out_ok) begin
        row_q <= row_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rho_q    <= in_data_q[DW-1:0];
      mom_q[0] <= in_data_q[2*DW-1:DW];
      mom_q[1] <= in_data_q[3*DW-1:2*DW];
      mom_q[2] <= in_data_q[4*DW-1:3*DW];
      e_q      <= in_data_q[5*DW-1:4*DW];
    end
    if (state_q == ST_SUM) begin
      sq_q <= KN_W'(lane_sq[0]) + KN_W'(lane_sq[1]) + KN_W'(lane_sq[2]);
    end
    if (state_q == ST_INNER) begin
      inner_q <= inner_d;
    end
    if (state_q == ST_PMUL) begin
      pprod_q <= gm1 * inner_q;
    end
    if (state_q == ST_PRES) begin
      p_q <= p_d;
    end
    if (state_q == ST_ROW0) begin
      h_q <= h_d;
    end
    if (out_load) begin
      out_data_q <= out_data_d;
      out_row_q  <= out_row_d;
      out_stat_q <= out_stat_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OTW'(out_data_q);
  assign m_axis_tuser_o  = {out_stat_q, out_row_q};
  assign m_axis_tlast_o  = out_last_q;

  assign out_err = out_valid_q && (out_stat_q != STATUS_OK);

  `ASSERT_CLK(a_in_buf_full, clk_i, rst_ni, in_acc |=> !s_axis_tready_o)
  `ASSERT_CLK(a_err_is_last, clk_i, rst_ni, out_err |-> m_axis_tlast_o)
  `ASSERT_NEVER(a_idle_div_busy, clk_i, rst_ni, state_q == ST_IDLE && kin_busy)

endmodule
`default_nettype wire

// ===== tb/euler_flux_3d_checker.sv =====
// Checker for euler_flux_3d: watches input and result transfers, predicts the
// flux rows of each accepted state and compares them. Depends on ef3_pkg.
module euler_flux_3d_checker import ef3_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [GAMMA_W-1:0] cfg_wdata_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic [159:0]       in_data_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic [95:0]        out_data_i,
  input  wire logic [4:0]         out_user_i,
  input  wire logic               out_last_i,
  output int                      errors_o,
  output int                      pending_o
);
  typedef struct packed {
    logic [ROW_W-1:0]    row;
    logic [31:0]         fx;
    logic [31:0]         fy;
    logic [31:0]         fz;
    logic [STATUS_W-1:0] status;
    logic                last;
  } flux_t;

  flux_t rows_q[$];
  logic [GAMMA_W-1:0] gamma_q;

  function automatic longint clip(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) / 65536;
  endfunction

  function automatic flux_t mk(logic [2:0] r, longint x, longint y, longint z,
                               logic [1:0] s, logic l);
    flux_t f;
    f.row = r; f.fx = x[31:0]; f.fy = y[31:0]; f.fz = z[31:0];
    f.status = s; f.last = l;
    return f;
  endfunction

  task automatic predict_flux(logic [159:0] d);
    longint rho, e, ke, inner, gm1, p, h, t;
    longint m[3];
    longint vel[3];
    longint f[3];
    logic [63:0] sq, a;
    rho = longint'($signed(d[31:0]));
    e = longint'($signed(d[159:128]));
    sq = 0;
    if (rho <= 0) begin
      rows_q.push_back(mk(ROW_MASS, 0, 0, 0, STATUS_BAD_RHO, 1'b1));
      return;
    end
    for (int i = 0; i < 3; i++) begin
      m[i] = longint'($signed(d[32*(i+1) +: 32]));
      vel[i] = clip((m[i] * 65536) / rho);
      a = (m[i] < 0) ? -m[i] : m[i];
      sq += a * a;
    end
    ke = longint'(sq / (64'(rho) * 2));
    inner = clip(e - ke);
    gm1 = longint'(gamma_q) - 65536;
    p = clip((gm1 * inner) / 65536);
    if (p < 0) begin
      rows_q.push_back(mk(ROW_MASS, 0, 0, 0, STATUS_NEG_P, 1'b1));
      return;
    end
    rows_q.push_back(mk(ROW_MASS, m[0], m[1], m[2], STATUS_OK, 1'b0));
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        t = qmul(m[i], vel[j]);
        if (i == j) t += p;
        f[j] = clip(t);
      end
      rows_q.push_back(mk(3'(i + 1), f[0], f[1], f[2], STATUS_OK, 1'b0));
    end
    h = clip(e + p);
    rows_q.push_back(mk(ROW_ENERGY, clip(qmul(h, vel[0])), clip(qmul(h, vel[1])),
                        clip(qmul(h, vel[2])), STATUS_OK, 1'b1));
  endtask

  flux_t got, want;
  assign pending_o = rows_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= GAMMA_RESET;
      errors_o <= 0;
    end else begin
      if (cfg_we_i) gamma_q <= cfg_wdata_i;
      if (in_valid_i && in_ready_i) predict_flux(in_data_i);
      if (out_valid_i && out_ready_i) begin
        got = mk(out_user_i[2:0], longint'($signed(out_data_i[31:0])),
                 longint'($signed(out_data_i[63:32])),
                 longint'($signed(out_data_i[95:64])), out_user_i[4:3], out_last_i);
        if (rows_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual %h", $time, got);
          errors_o <= errors_o + 1;
        end else begin
          want = rows_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/euler_flux_3d_tb.sv =====
// Testbench top for euler_flux_3d: clock, reset, gamma settings, state stimulus
// and verdict. Depends on ef3_pkg and euler_flux_3d_checker.
module euler_flux_3d_tb import ef3_pkg::*;;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [GAMMA_W-1:0] cfg_wdata = '0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [159:0] s_data = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [95:0] m_data;
  logic [4:0] m_user;
  logic m_last;
  int errors, pending;
  int send_idle = 0, recv_idle = 0;
  bit hold_recv = 0;

  always #4 clk_i = ~clk_i;

  euler_flux_3d u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_o(m_data),
    .m_axis_tuser_o(m_user), .m_axis_tlast_o(m_last)
  );

  euler_flux_3d_checker u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(s_valid), .in_ready_i(s_ready), .in_data_i(s_data),
    .out_valid_i(m_valid), .out_ready_i(m_ready), .out_data_i(m_data),
    .out_user_i(m_user), .out_last_i(m_last), .errors_o(errors), .pending_o(pending)
  );

  always @(negedge clk_i) begin
    m_ready <= !hold_recv && ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $signed($urandom_range(2047)) - 1024;
    endcase
  endfunction

  task automatic send_state(logic [31:0] rho, logic [31:0] mx, logic [31:0] my,
                            logic [31:0] mz, logic [31:0] e);
    while ($urandom_range(99) < send_idle) @(negedge clk_i);
    s_valid = 1'b1;
    s_data = {e, mz, my, mx, rho};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    @(negedge clk_i);
    s_valid = 1'b0;
  endtask

  task automatic send_random();
    logic [31:0] rho, e;
    if ($urandom_range(9) == 0) rho = rnd_word();
    else rho = $urandom_range(32'h00200000, 32'h00001000);
    if ($urandom_range(3) == 0) e = rnd_word();
    else e = $urandom_range(32'h01000000, 32'h00010000);
    send_state(rho, rnd_word(), rnd_word(), rnd_word(), e);
  endtask

  task automatic drain_and_set(logic [GAMMA_W-1:0] g);
    while (pending != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_state(32'h00010000, 32'h00010000, 32'h00020000, 32'hffff0000, 32'h00100000);
    send_state(32'h0, 32'h1, 32'h1, 32'h1, 32'h1);
    send_state(32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0);
    send_state(32'h00010000, 32'h00100000, 32'h0, 32'h0, 32'h00010000);
    send_state(32'h1, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    send_state(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h0, 32'h7fffffff);
    send_state(32'h00010000, 32'h0, 32'h0, 32'h0, 32'h80000000);
    send_state(32'hffffffff, 32'h0, 32'h0, 32'h0, 32'h0);
    send_state(32'h00008000, 32'h7fff0000, 32'h7fff0000, 32'h7fff0000, 32'h7fffffff);
    drain_and_set(18'd65536);
    send_state(32'h00010000, 32'h00010000, 32'h0, 32'h0, 32'h00100000);
    send_state(32'h00010000, 32'h00100000, 32'h0, 32'h0, 32'h00010000);
    drain_and_set(18'd65535);
    send_state(32'h00010000, 32'h0, 32'h0, 32'h0, 32'h00100000);
    send_state(32'h00010000, 32'h0, 32'h0, 32'h0, 32'hfff00000);
    drain_and_set(18'h3ffff);
    send_state(32'h00010000, 32'h00010000, 32'h0, 32'h0, 32'h7fffffff);
    drain_and_set(18'd0);
    send_state(32'h00010000, 32'h0, 32'h0, 32'h0, 32'h80000000);
    drain_and_set(18'd196608);
    send_state(32'h00010000, 32'h00030000, 32'h00010000, 32'h0, 32'h00200000);
    // long receiver hold while states keep coming
    hold_recv = 1;
    fork
      begin repeat (600) @(negedge clk_i); hold_recv = 0; end
      repeat (4) send_random();
    join
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 12 : (ph == 1) ? 58 : 0;
      recv_idle = (ph == 0) ? 58 : (ph == 1) ? 12 : 0;
      drain_and_set((ph == 0) ? GAMMA_RESET : 18'($urandom_range(196608, 65536)));
      for (int k = 0; k < 100; k++) send_random();
    end
    while (pending != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #6000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
